### src/eaps_pkg.sv
package eaps_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PW        = FRAC_BITS + 1;
  localparam int KW        = PW + 1;
  localparam int MW        = PW + KW;
  localparam int SW        = MW + 1;
  localparam int RW        = SW - FRAC_BITS;
  localparam int TDATA_W   = ((PW + 7) / 8) * 8;
  localparam int TUSER_W   = 2;
  localparam int IDX_W     = 2;

  localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  localparam logic [IDX_W-1:0] REG_LOOP_MODE     = 2'd0;
  localparam logic [IDX_W-1:0] REG_EASE_MODE     = 2'd1;
  localparam logic [IDX_W-1:0] REG_START_PHASE   = 2'd2;
  localparam logic [IDX_W-1:0] REG_NOTIFY_ENABLE = 2'd3;

  localparam logic [1:0] LOOP_NONE    = 2'd0;
  localparam logic [1:0] LOOP_RESTART = 2'd1;
  localparam logic [1:0] LOOP_BOUNCE  = 2'd2;

  localparam logic [1:0] EASE_ONE    = 2'd0;
  localparam logic [1:0] EASE_LINEAR = 2'd1;
  localparam logic [1:0] EASE_SMOOTH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SQUARE,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic square;
    logic mul;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } sts_t;

endpackage

### src/eased_animation_phase_stepper_core.sv
// Eased animation phase stepper: each input beat is one tick that moves a Q1.16 phase by
// step_size (in_tdata) forward or backward, clamped to [0, 1.0], with the loop mode deciding
// hold, restart or reverse at the top; each tick yields one output beat with the eased
// position (constant, linear or smoothstep) in out_tdata and finished/done_event in out_tuser.
// A tick runs the controller sequence of capture, phase update, square and multiply on one
// shared multiplier, and output load, held while the output stalls; the next tick is taken
// as soon as the sequence returns to idle, while the previous result may still wait in the
// output register. Configuration writes are always ready and take effect at once; writing
// start_phase reloads the phase and turns the direction forward unless a step overrides it.
module eased_animation_phase_stepper_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [eaps_pkg::TDATA_W-1:0]      in_tdata,   // step_size
  input  logic                              in_tuser,   // suppress_done
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [eaps_pkg::TDATA_W-1:0]      out_tdata,  // eased_position
  output logic [eaps_pkg::TUSER_W-1:0]      out_tuser,  // finished, done_event
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [eaps_pkg::IDX_W-1:0]        cfg_index,
  input  logic [eaps_pkg::PW-1:0]           cfg_data
);

  eaps_pkg::cmd_t cmd;
  eaps_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  eaps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eaps_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### src/eaps_ctrl.sv
module eaps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  eaps_pkg::sts_t sts,
  output eaps_pkg::cmd_t cmd
);

  eaps_pkg::state_t state_r;
  eaps_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eaps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      eaps_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = eaps_pkg::ST_STEP;
        end
      end
      eaps_pkg::ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = eaps_pkg::ST_SQUARE;
      end
      eaps_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = eaps_pkg::ST_MUL;
      end
      eaps_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = eaps_pkg::ST_OUT;
      end
      eaps_pkg::ST_OUT: begin
        if (!sts.out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = eaps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = eaps_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("more than one command active");
  a_capture_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.step) else $error("step did not follow capture");
  a_square_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.square |=> cmd.mul) else $error("multiply did not follow square");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !sts.out_stall) else $error("load into stalled output");
`endif

endmodule

### src/eaps_dp.sv
module eaps_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  eaps_pkg::cmd_t                   cmd,
  output eaps_pkg::sts_t                   sts,
  input  logic [eaps_pkg::TDATA_W-1:0]     in_tdata,
  input  logic                             in_tuser,
  input  logic                             cfg_valid,
  input  logic [eaps_pkg::IDX_W-1:0]       cfg_index,
  input  logic [eaps_pkg::PW-1:0]          cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [eaps_pkg::TDATA_W-1:0]     out_tdata,
  output logic [eaps_pkg::TUSER_W-1:0]     out_tuser
);

  logic [1:0]              loop_mode_r;
  logic [1:0]              ease_mode_r;
  logic                    notify_r;
  logic [eaps_pkg::PW-1:0] phase_r;
  logic                    fwd_r;
  logic [eaps_pkg::PW-1:0] step_r;
  logic                    suppress_r;
  logic [eaps_pkg::PW-1:0] t2_r;
  logic [eaps_pkg::RW-1:0] r_r;
  logic                    out_valid_r;
  logic [eaps_pkg::PW-1:0] out_pos_r;
  logic                    out_fin_r;
  logic                    out_done_r;

  logic [eaps_pkg::PW-1:0] phase_nxt;
  logic                    fwd_nxt;
  logic [eaps_pkg::PW:0]   sum;
  logic [eaps_pkg::PW-1:0] cfg_sat;
  logic [eaps_pkg::KW-1:0] k;
  logic [eaps_pkg::PW-1:0] mul_a;
  logic [eaps_pkg::KW-1:0] mul_b;
  logic [eaps_pkg::MW-1:0] prod;
  logic [eaps_pkg::SW-1:0] prod_rnd;
  logic [eaps_pkg::PW-1:0] eased;
  logic                    fin;

  assign cfg_sat = (cfg_data > eaps_pkg::ONE) ? eaps_pkg::ONE : cfg_data;
  assign sum     = {1'b0, phase_r} + {1'b0, step_r};

  always_comb begin
    phase_nxt = phase_r;
    fwd_nxt   = fwd_r;
    if (fwd_r) begin
      if (sum >= {1'b0, eaps_pkg::ONE}) begin
        if (loop_mode_r == eaps_pkg::LOOP_RESTART) begin
          phase_nxt = '0;
        end else begin
          phase_nxt = eaps_pkg::ONE;
          if (loop_mode_r == eaps_pkg::LOOP_BOUNCE) begin
            fwd_nxt = 1'b0;
          end
        end
      end else begin
        phase_nxt = sum[eaps_pkg::PW-1:0];
      end
    end else begin
      if (step_r >= phase_r) begin
        phase_nxt = '0;
        fwd_nxt   = 1'b1;
      end else begin
        phase_nxt = phase_r - step_r;
      end
    end
  end

  assign k        = eaps_pkg::KW'(3) * {1'b0, eaps_pkg::ONE} - {phase_r, 1'b0};
  assign mul_a    = cmd.square ? phase_r : t2_r;
  assign mul_b    = cmd.square ? {1'b0, phase_r} : k;
  assign prod     = {{eaps_pkg::KW{1'b0}}, mul_a} * {{eaps_pkg::PW{1'b0}}, mul_b};
  assign prod_rnd = {1'b0, prod} + eaps_pkg::HALF;

  always_comb begin
    case (ease_mode_r)
      eaps_pkg::EASE_ONE:    eased = eaps_pkg::ONE;
      eaps_pkg::EASE_LINEAR: eased = phase_r;
      eaps_pkg::EASE_SMOOTH: begin
        if (r_r > eaps_pkg::RW'(eaps_pkg::ONE)) begin
          eased = eaps_pkg::ONE;
        end else begin
          eased = r_r[eaps_pkg::PW-1:0];
        end
      end
      default:               eased = '0;
    endcase
  end

  assign fin = (loop_mode_r == eaps_pkg::LOOP_NONE) && (phase_r == eaps_pkg::ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_mode_r <= eaps_pkg::LOOP_NONE;
      ease_mode_r <= eaps_pkg::EASE_LINEAR;
      notify_r    <= 1'b0;
      phase_r     <= '0;
      fwd_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          eaps_pkg::REG_LOOP_MODE:     loop_mode_r <= cfg_data[1:0];
          eaps_pkg::REG_EASE_MODE:     ease_mode_r <= cfg_data[1:0];
          eaps_pkg::REG_START_PHASE: begin
            phase_r <= cfg_sat;
            fwd_r   <= 1'b1;
          end
          eaps_pkg::REG_NOTIFY_ENABLE: notify_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        phase_r <= phase_nxt;
        fwd_r   <= fwd_nxt;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      step_r     <= in_tdata[eaps_pkg::PW-1:0];
      suppress_r <= in_tuser;
    end
    if (cmd.square) begin
      t2_r <= prod_rnd[eaps_pkg::FRAC_BITS +: eaps_pkg::PW];
    end
    if (cmd.mul) begin
      r_r <= prod_rnd[eaps_pkg::SW-1:eaps_pkg::FRAC_BITS];
    end
    if (cmd.load) begin
      out_pos_r  <= eased;
      out_fin_r  <= fin;
      out_done_r <= fin && notify_r && !suppress_r;
    end
  end

  assign sts.out_stall = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {{(eaps_pkg::TDATA_W - eaps_pkg::PW){1'b0}}, out_pos_r};
  assign out_tuser     = {out_done_r, out_fin_r};

endmodule

### sim/tb.sv
module tb;

  localparam logic [1:0] LOOP_UNUSED = 2'd3;
  localparam logic [1:0] EASE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         RANDOM_TICKS = 1530;

  typedef struct packed {
    logic [eaps_pkg::PW-1:0] position;
    logic                    finished;
    logic                    done_event;
  } tick_result_t;

  class eased_position_tracker;
    logic [1:0]              loop_mode = eaps_pkg::LOOP_NONE;
    logic [1:0]              ease_mode = eaps_pkg::EASE_LINEAR;
    logic                    notify_en = 1'b0;
    logic [eaps_pkg::PW-1:0] phase     = '0;
    bit                      forward   = 1'b1;
    tick_result_t            pending_positions[$];
    int                      errors, ticks, results, done_events, reg_writes;

    function void apply_reg(logic [eaps_pkg::IDX_W-1:0] idx, logic [eaps_pkg::PW-1:0] val);
      reg_writes++;
      case (idx)
        eaps_pkg::REG_LOOP_MODE:   loop_mode = val[1:0];
        eaps_pkg::REG_EASE_MODE:   ease_mode = val[1:0];
        eaps_pkg::REG_START_PHASE: begin
          phase   = (val > eaps_pkg::ONE) ? eaps_pkg::ONE : val;
          forward = 1'b1;
        end
        eaps_pkg::REG_NOTIFY_ENABLE: notify_en = val[0];
        default: ;
      endcase
    endfunction

    function logic [eaps_pkg::PW-1:0] eased(logic [eaps_pkg::PW-1:0] t);
      longint unsigned tt, sq, prod, one_v, half_v;
      one_v  = eaps_pkg::ONE;
      half_v = longint'(1) << (eaps_pkg::FRAC_BITS - 1);
      tt     = t;
      case (ease_mode)
        eaps_pkg::EASE_ONE:    return eaps_pkg::ONE;
        eaps_pkg::EASE_LINEAR: return t;
        eaps_pkg::EASE_SMOOTH: begin
          sq   = (tt * tt + half_v) >> eaps_pkg::FRAC_BITS;
          prod = (sq * (3 * one_v - 2 * tt) + half_v) >> eaps_pkg::FRAC_BITS;
          return (prod > one_v) ? eaps_pkg::ONE : eaps_pkg::PW'(prod);
        end
        default: return '0;
      endcase
    endfunction

    function void note_tick(logic [eaps_pkg::PW-1:0] step, logic suppress);
      logic [eaps_pkg::PW:0] sum;
      tick_result_t          res;
      ticks++;
      if (forward) begin
        sum = {1'b0, phase} + {1'b0, step};
        if (sum >= {1'b0, eaps_pkg::ONE}) begin
          if (loop_mode == eaps_pkg::LOOP_RESTART) begin
            sum = '0;
          end else begin
            sum = {1'b0, eaps_pkg::ONE};
            if (loop_mode == eaps_pkg::LOOP_BOUNCE) forward = 1'b0;
          end
        end
        phase = sum[eaps_pkg::PW-1:0];
      end else if (step >= phase) begin
        phase   = '0;
        forward = 1'b1;
      end else begin
        phase = phase - step;
      end
      res.position   = eased(phase);
      res.finished   = (loop_mode == eaps_pkg::LOOP_NONE) && (phase >= eaps_pkg::ONE);
      res.done_event = res.finished && notify_en && !suppress;
      pending_positions.push_back(res);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [eaps_pkg::TDATA_W-1:0] data,
                               logic [eaps_pkg::TUSER_W-1:0] user);
      tick_result_t want;
      results++;
      if (user[1]) done_events++;
      if (pending_positions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none actual pos %0d user %b",
                 $time, data, user);
        return;
      end
      want = pending_positions.pop_front();
      compare_field("eased_position", want.position, data[eaps_pkg::PW-1:0]);
      compare_field("tdata padding", 0, data >> eaps_pkg::PW);
      compare_field("finished", want.finished, user[0]);
      compare_field("done_event", want.done_event, user[1]);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [eaps_pkg::TDATA_W-1:0]   in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [eaps_pkg::TDATA_W-1:0]   out_tdata;
  logic [eaps_pkg::TUSER_W-1:0]   out_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [eaps_pkg::IDX_W-1:0]     cfg_index = '0;
  logic [eaps_pkg::PW-1:0]        cfg_data = '0;

  eased_position_tracker tracker = new;
  int                    cycle_cnt = 0;
  bit [31:0]             rcv_tick = '0;
  logic [1:0]            rcv_mode = 2'd0;

  eased_animation_phase_stepper_core DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("eased_animation_phase_stepper_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_tick(in_tdata[eaps_pkg::PW-1:0], in_tuser);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
    end
  end

  // receiver: switch among random stall patterns
  always @(posedge clk) begin
    rcv_tick <= rcv_tick + 1;
    if (rcv_tick % 97 == 0) rcv_mode <= 2'($urandom_range(0, 3));
    case (rcv_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= (rcv_tick[2:0] == 3'd0);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic write_reg(logic [eaps_pkg::IDX_W-1:0] idx, logic [eaps_pkg::PW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(logic [eaps_pkg::PW-1:0] step, logic suppress, int gap);
    in_tvalid <= 1'b1;
    in_tdata  <= eaps_pkg::TDATA_W'(step);
    in_tuser  <= suppress;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, let the last accepted beat reach the tracker, then drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [eaps_pkg::PW-1:0] pick_step();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return eaps_pkg::PW'($urandom_range(0, 4096));
    if (sel < 75) return eaps_pkg::PW'($urandom_range(0, 32768));
    if (sel < 85) return eaps_pkg::PW'($urandom_range(32768, 65536));
    if (sel < 90) return '0;
    if (sel < 95) return eaps_pkg::ONE;
    return eaps_pkg::PW'($urandom_range(0, 65536));
  endfunction

  function automatic logic [eaps_pkg::PW-1:0] pick_start();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return eaps_pkg::ONE;
    if (sel == 2) return eaps_pkg::PW'($urandom_range(65537, 131071));
    return eaps_pkg::PW'($urandom_range(0, 65536));
  endfunction

  task automatic random_config();
    if ($urandom_range(0, 1))
      write_reg(eaps_pkg::REG_LOOP_MODE,
                ($urandom_range(0, 9) == 0) ? eaps_pkg::PW'(LOOP_UNUSED)
                                            : eaps_pkg::PW'($urandom_range(0, 2)));
    if ($urandom_range(0, 1))
      write_reg(eaps_pkg::REG_EASE_MODE,
                ($urandom_range(0, 9) == 0) ? eaps_pkg::PW'(EASE_UNUSED)
                                            : eaps_pkg::PW'($urandom_range(0, 2)));
    if ($urandom_range(0, 2) != 0) write_reg(eaps_pkg::REG_START_PHASE, pick_start());
    if ($urandom_range(0, 1))
      write_reg(eaps_pkg::REG_NOTIFY_ENABLE, eaps_pkg::PW'($urandom_range(0, 1)));
  endtask

  initial begin
    int sent, phases, burst, gap;
    sent   = 0;
    phases = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, then jump to the top with no notify
    send_tick('0, 1'b0, 0);
    send_tick(eaps_pkg::ONE, 1'b0, 1);
    wait_idle();

    // smoothstep, notify on, skip to end masked then done fires
    write_reg(eaps_pkg::REG_NOTIFY_ENABLE, 17'd1);
    write_reg(eaps_pkg::REG_EASE_MODE, eaps_pkg::PW'(eaps_pkg::EASE_SMOOTH));
    write_reg(eaps_pkg::REG_START_PHASE, 17'd0);
    send_tick(17'd16384, 1'b0, 0);
    send_tick(17'd16384, 1'b1, 0);
    send_tick(17'd1, 1'b0, 2);
    send_tick(eaps_pkg::ONE, 1'b1, 0);
    send_tick('0, 1'b0, 0);
    wait_idle();

    // restart loop, start phase above one saturates
    write_reg(eaps_pkg::REG_LOOP_MODE, eaps_pkg::PW'(eaps_pkg::LOOP_RESTART));
    write_reg(eaps_pkg::REG_START_PHASE, 17'd65537);
    send_tick('0, 1'b0, 0);
    send_tick(17'd40000, 1'b0, 0);
    send_tick(17'd40000, 1'b0, 0);
    wait_idle();

    // bounce, reverse at top, then leave bounce while moving backward
    write_reg(eaps_pkg::REG_LOOP_MODE, eaps_pkg::PW'(eaps_pkg::LOOP_BOUNCE));
    write_reg(eaps_pkg::REG_EASE_MODE, eaps_pkg::PW'(eaps_pkg::EASE_ONE));
    write_reg(eaps_pkg::REG_START_PHASE, 17'h1FFFF);
    send_tick(17'd1, 1'b0, 0);
    send_tick(17'd30000, 1'b0, 0);
    wait_idle();
    write_reg(eaps_pkg::REG_LOOP_MODE, eaps_pkg::PW'(eaps_pkg::LOOP_NONE));
    write_reg(eaps_pkg::REG_EASE_MODE, eaps_pkg::PW'(eaps_pkg::EASE_SMOOTH));
    send_tick(17'd20000, 1'b0, 0);
    send_tick(eaps_pkg::ONE, 1'b0, 0);
    send_tick(17'h0AAAA, 1'b1, 0);
    send_tick(17'h05555, 1'b0, 0);
    wait_idle();

    // unused loop and ease modes
    write_reg(eaps_pkg::REG_LOOP_MODE, eaps_pkg::PW'(LOOP_UNUSED));
    write_reg(eaps_pkg::REG_EASE_MODE, eaps_pkg::PW'(EASE_UNUSED));
    send_tick(eaps_pkg::ONE, 1'b0, 0);
    send_tick(17'd300, 1'b0, 0);
    wait_idle();

    while (sent < RANDOM_TICKS) begin
      int phase_len;
      random_config();
      phases++;
      phase_len = $urandom_range(40, 160);
      while (phase_len > 0 && sent < RANDOM_TICKS) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        while (burst > 0 && phase_len > 0 && sent < RANDOM_TICKS) begin
          send_tick(pick_step(), 1'($urandom_range(0, 1)),
                    (burst == 1 || phase_len == 1) ? gap : 0);
          burst--;
          phase_len--;
          sent++;
        end
      end
      in_tvalid <= 1'b0;
      wait_idle();
    end

    $display("covered %0d ticks over %0d random setting phases, %0d register writes",
             tracker.ticks, phases, tracker.reg_writes);
    $display("checked %0d result beats, %0d with done_event set",
             tracker.results, tracker.done_events);
    if (tracker.errors == 0) begin
      $display("eased_animation_phase_stepper_core verification clean");
    end else begin
      $display("eased_animation_phase_stepper_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/eaps_pkg.sv
src/eaps_ctrl.sv
src/eaps_dp.sv
src/eased_animation_phase_stepper_core.sv
sim/tb.sv
